[hdl/tcgr_pkg.sv]
`timescale 1ns / 1ps

package tcgr_pkg;

    // Request field widths
    localparam int KIND_W     = 2;
    localparam int CHAR_W     = 8;
    localparam int FIDX_W     = 12;
    localparam int FBYTE_W    = 8;

    // Result field widths
    localparam int OFFSET_W   = 26;
    localparam int BITS_W     = 8;

    // Cursor and configuration widths
    localparam int ROW_W      = 10;
    localparam int COL_W      = 9;
    localparam int WIDTH_W    = 13;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    // Request kinds
    localparam logic [KIND_W-1:0] KIND_DRAW = 2'd0;
    localparam logic [KIND_W-1:0] KIND_LOAD = 2'd1;
    localparam logic [KIND_W-1:0] KIND_HOME = 2'd2;

    // Control characters
    localparam logic [CHAR_W-1:0] CH_TAB     = 8'd9;
    localparam logic [CHAR_W-1:0] CH_NEWLINE = 8'd10;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_EN = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_WIDTH    = 2'd1;

    // Reset values and cursor limits
    localparam logic [WIDTH_W-1:0] WIDTH_RESET = 13'd640;
    localparam logic [ROW_W-1:0]   ROW_MAX     = '1;
    localparam logic [COL_W-1:0]   COL_MAX     = '1;

endpackage

[hdl/tcgr_if.sv]
`timescale 1ns / 1ps

// Command channel: draw, font load and cursor home requests
interface tcgr_cmd_if;
    import tcgr_pkg::*;

    logic               valid;
    logic               ready;
    logic [KIND_W-1:0]  kind;
    logic [CHAR_W-1:0]  char_code;
    logic [FIDX_W-1:0]  font_index;
    logic [FBYTE_W-1:0] font_byte;

    modport source (output valid, kind, char_code, font_index, font_byte, input ready);
    modport sink   (input valid, kind, char_code, font_index, font_byte, output ready);
endinterface

// Result channel: one glyph row per result
interface tcgr_res_if;
    import tcgr_pkg::*;

    logic                valid;
    logic                ready;
    logic [OFFSET_W-1:0] pixel_offset;
    logic [BITS_W-1:0]   glyph_bits;
    logic                is_last;

    modport source (output valid, pixel_offset, glyph_bits, is_last, input ready);
    modport sink   (input valid, pixel_offset, glyph_bits, is_last, output ready);
endinterface

[hdl/tcgr_ram.sv]
`timescale 1ns / 1ps

// Simple dual-port RAM, one write and one registered read port, read-first
module tcgr_ram #(
    parameter int  WIDTH = 8,
    parameter int  DEPTH = 4096,
    localparam int AddrW = $clog2(DEPTH)
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AddrW-1:0] waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AddrW-1:0] raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

[hdl/text_console_glyph_renderer_top.sv]
`timescale 1ns / 1ps

// Text console glyph renderer. Requests on cmd either load a font byte, home the
// cursor or draw a character. A drawn character produces GLYPH_ROWS results on res,
// one glyph row per cycle while res is not stalled, as the font memory read port
// steps through the glyph; each carries the framebuffer pixel offset of the row's
// leftmost pixel and its eight glyph bits (bit j lands on offset + j). A draw holds
// the block until its last row is read; the next request is taken in that cycle,
// and loads, home, newline and tab do not hold it. A glyph row passes the sequencer,
// read stage and output register before it reaches res. Colours are applied
// downstream: writes to the colour registers are accepted and ignored here. The font
// memory needs no clearing after reset; glyphs must be loaded before they are drawn.
module text_console_glyph_renderer_top #(
    parameter int GLYPH_ROWS = 16,
    parameter int FONT_CHARS = 256
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic [tcgr_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [tcgr_pkg::CFG_DATA_W-1:0] cfg_data,
    tcgr_cmd_if.sink                        cmd,
    tcgr_res_if.source                      res
);
    import tcgr_pkg::*;

    localparam int DEPTH  = FONT_CHARS * GLYPH_ROWS;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int CNT_W  = $clog2(GLYPH_ROWS);
    localparam int LINE_W = ROW_W + CNT_W;
    localparam int PROD_W = LINE_W + WIDTH_W;
    localparam int FIDX_WIDE_W = ADDR_W + FIDX_W;
    localparam int CADDR_W = ADDR_W + CHAR_W;

    localparam logic [CNT_W-1:0]       CNT_LAST   = CNT_W'(GLYPH_ROWS - 1);
    localparam logic [FIDX_WIDE_W-1:0] DEPTH_WIDE = FIDX_WIDE_W'(DEPTH);

    // Configuration
    logic               frame_en_reg;
    logic [WIDTH_W-1:0] width_pixels_reg;

    // Cursor
    logic [ROW_W-1:0] row_reg, row_next;
    logic [COL_W-1:0] col_reg, col_next;

    // Glyph sequencer
    logic              seq_busy_reg, seq_busy_next;
    logic [CNT_W-1:0]  seq_cnt_reg, seq_cnt_next;
    logic [LINE_W-1:0] seq_line_reg;
    logic [ADDR_W-1:0] seq_addr_reg;
    logic [COL_W-1:0]  seq_col_reg;
    logic              seq_blank_reg;

    // Read stage, aligned with font memory data
    logic                b_valid_reg, b_valid_next;
    logic [OFFSET_W-1:0] b_offset_reg;
    logic                b_last_reg;
    logic                b_blank_reg;

    // Output register
    logic                o_valid_reg, o_valid_next;
    logic [OFFSET_W-1:0] o_offset_reg;
    logic [BITS_W-1:0]   o_bits_reg;
    logic                o_last_reg;

    logic cmd_acc, is_draw, is_load, is_home;
    logic draw_nl, draw_tab, draw_glyph, start;
    logic issue, seq_last, b_free, out_load;
    logic load_in_range;

    logic [FIDX_WIDE_W-1:0] fidx_wide;
    logic [CADDR_W-1:0]     char_addr;
    logic [COL_W:0]         tab_sum;
    logic [COL_W-1:0]       tab_col;
    logic                   tab_wrap;
    logic [ROW_W-1:0]       row_inc;
    logic [PROD_W-1:0]      line_prod;
    logic [PROD_W-1:0]      offset_sum;
    logic [BITS_W-1:0]      ram_rdata;

    // Request decode
    assign cmd_acc    = cmd.valid && cmd.ready;
    assign is_draw    = (cmd.kind == KIND_DRAW) && frame_en_reg;
    assign is_load    = (cmd.kind == KIND_LOAD);
    assign is_home    = (cmd.kind == KIND_HOME);
    assign draw_nl    = is_draw && (cmd.char_code == CH_NEWLINE);
    assign draw_tab   = is_draw && (cmd.char_code == CH_TAB);
    assign draw_glyph = is_draw && !draw_nl && !draw_tab;
    assign start      = cmd_acc && draw_glyph;

    // Pipeline flow
    assign out_load = b_valid_reg && (!o_valid_reg || res.ready);
    assign b_free   = !b_valid_reg || out_load;
    assign issue    = seq_busy_reg && b_free;
    assign seq_last = issue && (seq_cnt_reg == CNT_LAST);

    assign cmd.ready = !seq_busy_reg || seq_last;

    // Font load address check
    assign fidx_wide     = FIDX_WIDE_W'(cmd.font_index);
    assign load_in_range = fidx_wide < DEPTH_WIDE;

    // Cursor arithmetic
    assign tab_sum  = {1'b0, col_reg | COL_W'(7)} + (COL_W + 1)'(1);
    assign tab_col  = tab_sum[COL_W] ? COL_MAX : tab_sum[COL_W-1:0];
    assign tab_wrap = {1'b0, tab_col} > width_pixels_reg[WIDTH_W-1:3];
    assign row_inc  = (row_reg == ROW_MAX) ? row_reg : row_reg + ROW_W'(1);

    always_comb
    begin
        row_next = row_reg;
        col_next = col_reg;
        if (cmd_acc)
        begin
            if (is_home)
            begin
                row_next = '0;
                col_next = '0;
            end
            else if (draw_nl || (draw_tab && tab_wrap))
            begin
                row_next = row_inc;
                col_next = '0;
            end
            else if (draw_tab)
            begin
                col_next = tab_col;
            end
            else if (draw_glyph && (col_reg != COL_MAX))
            begin
                col_next = col_reg + COL_W'(1);
            end
        end
    end

    // Sequencer, read stage and output control
    always_comb
    begin
        seq_busy_next = seq_busy_reg;
        seq_cnt_next  = seq_cnt_reg;
        if (start)
        begin
            seq_busy_next = 1'b1;
            seq_cnt_next  = '0;
        end
        else if (issue)
        begin
            seq_busy_next = !seq_last;
            seq_cnt_next  = seq_cnt_reg + CNT_W'(1);
        end

        b_valid_next = b_valid_reg;
        if (issue)
        begin
            b_valid_next = 1'b1;
        end
        else if (out_load)
        begin
            b_valid_next = 1'b0;
        end

        o_valid_next = o_valid_reg;
        if (out_load)
        begin
            o_valid_next = 1'b1;
        end
        else if (res.ready)
        begin
            o_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_en_reg     <= 1'b0;
            width_pixels_reg <= WIDTH_RESET;
            row_reg          <= '0;
            col_reg          <= '0;
            seq_busy_reg     <= 1'b0;
            seq_cnt_reg      <= '0;
            b_valid_reg      <= 1'b0;
            o_valid_reg      <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_FRAME_EN: frame_en_reg     <= cfg_data[0];
                    CFG_WIDTH:    width_pixels_reg <= cfg_data[WIDTH_W-1:0];
                    default:      ; // colours are applied downstream
                endcase
            end
            row_reg      <= row_next;
            col_reg      <= col_next;
            seq_busy_reg <= seq_busy_next;
            seq_cnt_reg  <= seq_cnt_next;
            b_valid_reg  <= b_valid_next;
            o_valid_reg  <= o_valid_next;
        end
    end

    // Glyph base address of the drawn character
    assign char_addr = CADDR_W'(cmd.char_code) * CADDR_W'(GLYPH_ROWS);

    // Pixel offset of the row being read
    assign line_prod  = PROD_W'(seq_line_reg) * PROD_W'(width_pixels_reg);
    assign offset_sum = line_prod + PROD_W'({seq_col_reg, 3'b000});

    // Sequencer payload
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            seq_line_reg  <= LINE_W'(row_reg) * LINE_W'(GLYPH_ROWS);
            seq_addr_reg  <= char_addr[ADDR_W-1:0];
            seq_col_reg   <= col_reg;
            seq_blank_reg <= (CHAR_W + 1)'(cmd.char_code) >= (CHAR_W + 1)'(FONT_CHARS);
        end
        else if (issue)
        begin
            seq_line_reg <= seq_line_reg + LINE_W'(1);
            seq_addr_reg <= seq_addr_reg + ADDR_W'(1);
        end
    end

    // Read stage and output payload
    always_ff @(posedge clk)
    begin
        if (issue)
        begin
            b_offset_reg <= offset_sum[OFFSET_W-1:0];
            b_last_reg   <= (seq_cnt_reg == CNT_LAST);
            b_blank_reg  <= seq_blank_reg;
        end
        if (out_load)
        begin
            o_offset_reg <= b_offset_reg;
            o_bits_reg   <= b_blank_reg ? '0 : ram_rdata;
            o_last_reg   <= b_last_reg;
        end
    end

    // Font store
    tcgr_ram #(
        .WIDTH (BITS_W),
        .DEPTH (DEPTH)
    ) u_font (
        .clk   (clk),
        .we    (cmd_acc && is_load && load_in_range),
        .waddr (fidx_wide[ADDR_W-1:0]),
        .wdata (cmd.font_byte),
        .re    (issue),
        .raddr (seq_addr_reg),
        .rdata (ram_rdata)
    );

    assign res.valid        = o_valid_reg;
    assign res.pixel_offset = o_offset_reg;
    assign res.glyph_bits   = o_bits_reg;
    assign res.is_last      = o_last_reg;

`ifndef SYNTHESIS
    // A started glyph begins at its first row
    a_start_first_row: assert property (@(posedge clk) disable iff (!rst_n)
        start |=> seq_busy_reg && (seq_cnt_reg == '0))
        else $error("glyph sequencer did not start at row zero");

    // Row counter never runs past the last glyph row
    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        seq_busy_reg |-> (seq_cnt_reg <= CNT_LAST))
        else $error("glyph row counter out of range");

    // A stalled read stage keeps its offset and memory data
    a_read_hold: assert property (@(posedge clk) disable iff (!rst_n)
        b_valid_reg && !out_load |=> b_valid_reg && $stable(b_offset_reg)
            && $stable(ram_rdata))
        else $error("read stage lost data while stalled");
`endif

endmodule

[bench/tb.sv]
`timescale 1ns / 1ps

module tb;
    import tcgr_pkg::*;

    localparam int GLYPH_ROWS   = 16;
    localparam int FONT_CHARS   = 256;
    localparam int FONT_DEPTH   = FONT_CHARS * GLYPH_ROWS;
    localparam int DRAIN_CYCLES = GLYPH_ROWS + 8;
    localparam int HOLD_CYCLES  = 300;
    localparam int MAX_LINES    = 40;

    // Codes the package leaves unnamed
    localparam logic [KIND_W-1:0]    KIND_SPARE = 2'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_FG     = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_BG     = 2'd3;

    localparam longint unsigned OFFSET_MASK = (64'd1 << OFFSET_W) - 64'd1;

    typedef struct packed {
        logic [KIND_W-1:0]  kind;
        logic [CHAR_W-1:0]  char_code;
        logic [FIDX_W-1:0]  font_index;
        logic [FBYTE_W-1:0] font_byte;
    } console_req_t;

    typedef struct packed {
        logic [OFFSET_W-1:0] pixel_offset;
        logic [BITS_W-1:0]   glyph_bits;
        logic                is_last;
    } glyph_row_t;

    // Cursor, font and register shadow; queues the glyph rows each request should give
    class glyph_row_tracker;
        glyph_row_t         rows_due[$];
        int                 errors;
        int                 rows_checked;
        bit                 frame_on;
        logic [WIDTH_W-1:0] line_width;
        logic [ROW_W-1:0]   cur_row;
        logic [COL_W-1:0]   cur_col;
        logic [7:0]         glyphs[FONT_DEPTH];

        function new();
            errors       = 0;
            rows_checked = 0;
            frame_on     = 1'b0;
            line_width   = WIDTH_RESET;
            cur_row      = '0;
            cur_col      = '0;
            foreach (glyphs[i])
                glyphs[i] = '0;
        endfunction

        // Colour registers do not reach the results
        function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                CFG_FRAME_EN: frame_on   = data[0];
                CFG_WIDTH:    line_width = data[WIDTH_W-1:0];
                default: ;
            endcase
        endfunction

        function void next_line();
            cur_col = '0;
            if (cur_row != ROW_MAX)
                cur_row = cur_row + 1'b1;
        endfunction

        function void note_request(console_req_t r);
            int unsigned     tab_col;
            longint unsigned line;
            longint unsigned offset;
            glyph_row_t      row_exp;
            case (r.kind)
                KIND_LOAD:
                    if (int'(r.font_index) < FONT_DEPTH)
                        glyphs[r.font_index] = r.font_byte;
                KIND_HOME:
                begin
                    cur_row = '0;
                    cur_col = '0;
                end
                KIND_DRAW:
                    if (frame_on)
                    begin
                        if (r.char_code == CH_NEWLINE)
                            next_line();
                        else if (r.char_code == CH_TAB)
                        begin
                            tab_col = cur_col + (8 - (cur_col % 8));
                            if (tab_col > COL_MAX)
                                tab_col = COL_MAX;
                            cur_col = tab_col[COL_W-1:0];
                            if (cur_col > (line_width >> 3))
                                next_line();
                        end
                        else
                        begin
                            for (int g = 0; g < GLYPH_ROWS; g++)
                            begin
                                line   = 64'(cur_row) * GLYPH_ROWS + g;
                                offset = (line * line_width + 64'(cur_col) * 8) & OFFSET_MASK;
                                row_exp.pixel_offset = offset[OFFSET_W-1:0];
                                row_exp.glyph_bits   = (int'(r.char_code) < FONT_CHARS) ?
                                    glyphs[int'(r.char_code) * GLYPH_ROWS + g] : '0;
                                row_exp.is_last      = (g == GLYPH_ROWS - 1);
                                rows_due.push_back(row_exp);
                            end
                            if (cur_col != COL_MAX)
                                cur_col = cur_col + 1'b1;
                        end
                    end
                default: ;
            endcase
        endfunction

        task report(string msg);
            errors++;
            if (errors <= MAX_LINES)
                $display("mismatch at %0t: %s", $realtime, msg);
        endtask

        task check_row(glyph_row_t got);
            glyph_row_t want;
            if (rows_due.size() == 0)
            begin
                report($sformatf("unexpected row offset %0d bits %02h last %0b",
                                 got.pixel_offset, got.glyph_bits, got.is_last));
                return;
            end
            want = rows_due.pop_front();
            rows_checked++;
            if (got.pixel_offset !== want.pixel_offset)
                report($sformatf("pixel_offset %0d, wanted %0d",
                                 got.pixel_offset, want.pixel_offset));
            if (got.glyph_bits !== want.glyph_bits)
                report($sformatf("glyph_bits %02h, wanted %02h at offset %0d",
                                 got.glyph_bits, want.glyph_bits, want.pixel_offset));
            if (got.is_last !== want.is_last)
                report($sformatf("is_last %0b, wanted %0b at offset %0d",
                                 got.is_last, want.is_last, want.pixel_offset));
        endtask
    endclass

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    tcgr_cmd_if cmd_bus();
    tcgr_res_if res_bus();

    text_console_glyph_renderer_top #(
        .GLYPH_ROWS(GLYPH_ROWS),
        .FONT_CHARS(FONT_CHARS)
    ) dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_we   (cfg_we),
        .cfg_index(cfg_index),
        .cfg_data (cfg_data),
        .cmd      (cmd_bus),
        .res      (res_bus)
    );

    glyph_row_tracker tracker;

    // Stimulus bookkeeping: which font entries hold data, which glyphs may be drawn
    bit         font_set[FONT_DEPTH];
    bit         listed[FONT_CHARS];
    logic [7:0] drawable[$];
    int         send_calm;
    int         take_calm;
    bit         hold_results;
    int         n_reqs;
    int         n_settings;

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // Watchdog
    initial
    begin
        #5ms;
        $display("[text_console_glyph_renderer_top] ERROR");
        $finish;
    end

    // Random wait before each item, with occasional runs of back-to-back items
    function automatic int pick_wait(inout int calm);
        if (calm > 0)
        begin
            calm--;
            return 0;
        end
        if ($urandom_range(0, 15) == 0)
        begin
            calm = $urandom_range(10, 30);
            return 0;
        end
        return $urandom_range(0, 8);
    endfunction

    // Request of the given kind and character; unused fields carry noise
    function automatic console_req_t req_of(logic [KIND_W-1:0] kind, logic [7:0] ch);
        console_req_t r;
        r           = console_req_t'($urandom);
        r.kind      = kind;
        r.char_code = ch;
        return r;
    endfunction

    function automatic console_req_t load_req(logic [FIDX_W-1:0] idx, logic [7:0] fbyte);
        console_req_t r;
        r            = req_of(KIND_LOAD, 8'($urandom));
        r.font_index = idx;
        r.font_byte  = fbyte;
        return r;
    endfunction

    function automatic bit glyph_complete(int ch);
        for (int g = 0; g < GLYPH_ROWS; g++)
            if (!font_set[ch * GLYPH_ROWS + g])
                return 1'b0;
        return 1'b1;
    endfunction

    task automatic send_req(input console_req_t r);
        int gap;
        int ch;
        gap = pick_wait(send_calm);
        if (gap > 0)
        begin
            cmd_bus.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        cmd_bus.valid      <= 1'b1;
        cmd_bus.kind       <= r.kind;
        cmd_bus.char_code  <= r.char_code;
        cmd_bus.font_index <= r.font_index;
        cmd_bus.font_byte  <= r.font_byte;
        @(posedge clk);
        while (!cmd_bus.ready)
            @(posedge clk);
        tracker.note_request(r);
        n_reqs++;
        if (r.kind == KIND_LOAD && int'(r.font_index) < FONT_DEPTH)
        begin
            font_set[r.font_index] = 1'b1;
            ch = int'(r.font_index) / GLYPH_ROWS;
            if (!listed[ch] && glyph_complete(ch))
            begin
                listed[ch] = 1'b1;
                drawable.push_back(8'(ch));
            end
        end
    endtask

    // Full glyph: each row is (random & keep) | force
    task automatic load_glyph(input logic [7:0] ch, input logic [7:0] keep,
                              input logic [7:0] force_on);
        for (int g = 0; g < GLYPH_ROWS; g++)
            send_req(load_req(FIDX_W'(int'(ch) * GLYPH_ROWS + g),
                              (8'($urandom) & keep) | force_on));
    endtask

    // Let the block drain before touching registers
    task automatic settle();
        cmd_bus.valid <= 1'b0;
        while (tracker.rows_due.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic apply_settings(input logic en, input int unsigned width,
                                  input logic [15:0] fg, input logic [15:0] bg);
        logic [CFG_IDX_W-1:0]  idxs[4];
        logic [CFG_DATA_W-1:0] vals[4];
        settle();
        idxs = '{CFG_FRAME_EN, CFG_WIDTH, CFG_FG, CFG_BG};
        vals = '{CFG_DATA_W'(en), CFG_DATA_W'(width), fg, bg};
        for (int i = 0; i < 4; i++)
        begin
            cfg_we    <= 1'b1;
            cfg_index <= idxs[i];
            cfg_data  <= vals[i];
            @(posedge clk);
            tracker.set_reg(idxs[i], vals[i]);
        end
        cfg_we <= 1'b0;
        n_settings++;
    endtask

    // Mostly draws of loaded glyphs, with cursor moves, loads and spare-kind noise
    task automatic random_phase(input int count);
        int           useful;
        int           pick;
        console_req_t r;
        useful = 0;
        while (useful < count)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 55)
            begin
                r = req_of(KIND_DRAW, 8'($urandom));
                if (tracker.frame_on)
                begin
                    r.char_code = drawable[$urandom_range(0, drawable.size() - 1)];
                    useful++;
                end
                send_req(r);
            end
            else if (pick < 63)
            begin
                send_req(req_of(KIND_DRAW, CH_NEWLINE));
                useful += tracker.frame_on;
            end
            else if (pick < 71)
            begin
                send_req(req_of(KIND_DRAW, CH_TAB));
                useful += tracker.frame_on;
            end
            else if (pick < 75)
            begin
                send_req(req_of(KIND_HOME, 8'($urandom)));
                useful++;
            end
            else if (pick < 90)
            begin
                send_req(req_of(KIND_LOAD, 8'($urandom)));
                useful++;
            end
            else if (pick < 93)
            begin
                load_glyph(8'($urandom), 8'hFF, 8'h00);
                useful += GLYPH_ROWS;
            end
            else
                send_req(req_of(KIND_SPARE, 8'($urandom)));
        end
    endtask

    // Result side: random stalls, one long hold when asked
    initial
    begin : result_sink
        int         stall;
        glyph_row_t got;
        res_bus.ready <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            if (hold_results)
            begin
                hold_results = 1'b0;
                stall        = HOLD_CYCLES;
            end
            else
                stall = pick_wait(take_calm);
            if (stall > 0)
            begin
                res_bus.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            res_bus.ready <= 1'b1;
            @(posedge clk);
            while (!res_bus.valid)
                @(posedge clk);
            got.pixel_offset = res_bus.pixel_offset;
            got.glyph_bits   = res_bus.glyph_bits;
            got.is_last      = res_bus.is_last;
            tracker.check_row(got);
        end
    end

    initial
    begin : stimulus
        tracker            = new();
        send_calm          = 0;
        take_calm          = 0;
        hold_results       = 1'b0;
        n_reqs             = 0;
        n_settings         = 0;
        rst_n              <= 1'b0;
        cfg_we             <= 1'b0;
        cfg_index          <= '0;
        cfg_data           <= '0;
        cmd_bus.valid      <= 1'b0;
        cmd_bus.kind       <= KIND_HOME;
        cmd_bus.char_code  <= '0;
        cmd_bus.font_index <= '0;
        cmd_bus.font_byte  <= '0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Font preload: blank glyph at the bottom of the store, solid one at the top
        load_glyph(8'h00, 8'h00, 8'h00);
        load_glyph(8'hFF, 8'h00, 8'hFF);
        load_glyph(8'h41, 8'hFF, 8'h00);

        // Frame is off after reset, so this draw must stay silent
        send_req(req_of(KIND_DRAW, 8'h41));

        // Basic drawing, tab, newline, home and spare kind at reset width
        apply_settings(1'b1, WIDTH_RESET, 16'hFFFF, 16'h0000);
        send_req(req_of(KIND_DRAW, 8'h00));
        send_req(req_of(KIND_DRAW, 8'hFF));
        send_req(req_of(KIND_DRAW, 8'h41));
        send_req(req_of(KIND_DRAW, CH_TAB));
        send_req(req_of(KIND_DRAW, 8'h41));
        send_req(req_of(KIND_DRAW, CH_NEWLINE));
        send_req(req_of(KIND_DRAW, 8'hFF));
        send_req(req_of(KIND_SPARE, 8'h41));
        send_req(req_of(KIND_DRAW, CH_TAB));
        send_req(req_of(KIND_DRAW, CH_TAB));
        send_req(req_of(KIND_HOME, 8'hFF));
        send_req(req_of(KIND_DRAW, 8'h00));

        // Narrowest line: every tab wraps to the next row
        apply_settings(1'b1, 8, 16'h0000, 16'hFFFF);
        send_req(req_of(KIND_DRAW, CH_TAB));
        send_req(req_of(KIND_DRAW, 8'h41));
        send_req(req_of(KIND_DRAW, CH_TAB));
        send_req(req_of(KIND_DRAW, CH_NEWLINE));
        send_req(req_of(KIND_DRAW, 8'hFF));

        // Frame absent: draws and moves ignored, home and loads still act
        apply_settings(1'b0, WIDTH_RESET, 16'h1234, 16'hABCD);
        send_req(req_of(KIND_DRAW, 8'h41));
        send_req(req_of(KIND_DRAW, CH_NEWLINE));
        send_req(req_of(KIND_DRAW, CH_TAB));
        send_req(req_of(KIND_HOME, 8'h00));
        send_req(load_req('1, 8'h81));
        apply_settings(1'b1, WIDTH_RESET, 16'hFFFF, 16'h0000);
        send_req(req_of(KIND_DRAW, 8'hFF));

        // Column limit: tabs pin the column at its maximum, draws there keep it
        apply_settings(1'b1, 4096, 16'($urandom), 16'($urandom));
        send_req(req_of(KIND_HOME, 8'($urandom)));
        repeat (64) send_req(req_of(KIND_DRAW, CH_TAB));
        send_req(req_of(KIND_DRAW, 8'h41));
        send_req(req_of(KIND_DRAW, 8'hFF));
        send_req(req_of(KIND_DRAW, CH_TAB));

        // Widest register value: largest line width in the offset product
        apply_settings(1'b1, 8191, 16'h0000, 16'h0000);
        send_req(req_of(KIND_DRAW, 8'h41));
        send_req(req_of(KIND_DRAW, CH_TAB));
        send_req(req_of(KIND_DRAW, 8'hFF));

        // Random phases; the first holds results back long enough to stall requests
        apply_settings(1'b1, WIDTH_RESET, 16'hFFFF, 16'h0000);
        send_req(req_of(KIND_HOME, 8'($urandom)));
        hold_results = 1'b1;
        random_phase(20);
        apply_settings(1'b1, 8, 16'h0000, 16'hFFFF);
        random_phase(10);
        apply_settings(1'b0, $urandom_range(8, 4096), 16'($urandom), 16'($urandom));
        random_phase(4);
        apply_settings(1'b1, 4096, 16'($urandom), 16'($urandom));
        random_phase(10);
        apply_settings(1'b1, $urandom_range(8, 8191), 16'($urandom), 16'($urandom));
        random_phase(10);

        // Drain, then look for rows that never came
        cmd_bus.valid <= 1'b0;
        for (int i = 0; i < 20000 && tracker.rows_due.size() != 0; i++)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (tracker.rows_due.size() != 0)
            tracker.report($sformatf("%0d glyph rows never arrived", tracker.rows_due.size()));

        $display("run covered %0d requests over %0d register settings, %0d glyphs loadable",
                 n_reqs, n_settings, drawable.size());
        $display("%0d glyph rows compared, %0d mismatches", tracker.rows_checked, tracker.errors);
        if (tracker.errors == 0)
            $display("[text_console_glyph_renderer_top] OK");
        else
            $display("[text_console_glyph_renderer_top] ERROR");
        $finish;
    end

endmodule
